// File: hw/rtl/assert_macros.svh
// assertion macros used by the vector alu top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define VAU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vau assertion failed");

// consequence in the cycle after the antecedent, also checked during reset
`define VAU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vau assertion failed");

`endif

// File: hw/rtl/vau_pkg.sv
// shared types and opcode codes of the vector alu
package vau_pkg;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_MUL       = 4'd2,
    OP_DIV       = 4'd3,
    OP_SCALE     = 4'd4,
    OP_DIVSCALAR = 4'd5,
    OP_LEN       = 4'd6,
    OP_LENSQ     = 4'd7,
    OP_DIST      = 4'd8,
    OP_NORM      = 4'd9,
    OP_DOT       = 4'd10,
    OP_CROSS     = 4'd11
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } tag_t;

endpackage

// File: hw/rtl/vau_front.sv
// front pipeline: add and subtract, six multipliers, product combine and saturation
module vau_front import vau_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  tag_t                  tag_in,
  input  logic [2:0][W-1:0]     a,
  input  logic [2:0][W-1:0]     b,
  input  logic [W-1:0]          f,
  output tag_t                  tag_out,
  output logic [2:0][W-1:0]     fast_vec,
  output logic [W-1:0]          fast_sc,
  output logic                  fast_ovf,
  output logic [2*W-1:0]        sumsq,
  output logic [2:0][W-1:0]     n_mag,
  output logic [2:0]            n_neg,
  output logic [2:0][W-1:0]     d_mag,
  output logic [2:0]            d_neg
);

  localparam int XW = 2*W + 3;
  localparam logic signed [XW-1:0] SMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SMIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  // returns {overflow, saturated word}
  function automatic logic [W:0] sat(input logic signed [XW-1:0] v);
    if (v > SMAX) begin
      return {1'b1, SMAX[W-1:0]};
    end else if (v < SMIN) begin
      return {1'b1, SMIN[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic signed [XW-1:0] sx(input logic [W-1:0] x);
    return XW'(signed'(x));
  endfunction

  function automatic logic signed [XW-1:0] sxp(input logic [2*W-1:0] p);
    return XW'(signed'(p));
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (~x) + W'(1) : x;
  endfunction

  // stage 1: operand capture, add/sub and distance differences
  logic              v1;
  op_t               op1;
  logic [2:0][W-1:0] a1, b1;
  logic [W-1:0]      f1;
  logic [2:0][W:0]   as1, df1;
  logic [2:0][W:0]   as_c, df_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (tag_in.op == OP_SUB) begin
        as_c[i] = sat(sx(a[i]) - sx(b[i]));
      end else begin
        as_c[i] = sat(sx(a[i]) + sx(b[i]));
      end
      df_c[i] = sat(sx(b[i]) - sx(a[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= tag_in.op;
      a1  <= a;
      b1  <= b;
      f1  <= f;
      as1 <= as_c;
      df1 <= df_c;
    end
  end

  // stage 2: multiplier operand select and products
  logic [5:0][W-1:0]   mx, my;
  logic [2:0][W-1:0]   nm_c, dm_c;
  logic [2:0]          nn_c, dn_c;
  logic                v2;
  op_t                 op2;
  logic [5:0][2*W-1:0] p2;
  logic [2:0][W-1:0]   asv2;
  logic                asov2, dov2;
  logic [2:0][W-1:0]   nm2, dm2;
  logic [2:0]          nn2, dn2;

  always_comb begin
    mx = '0;
    my = '0;
    for (int i = 0; i < 3; i++) begin
      nm_c[i] = mag(a1[i]);
      nn_c[i] = a1[i][W-1];
      dm_c[i] = '0;
      dn_c[i] = 1'b0;
    end
    unique case (op1)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = a1[i];
          my[i] = f1;
        end
      end
      OP_LEN, OP_LENSQ, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = a1[i];
          my[i] = a1[i];
        end
      end
      OP_DIST: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = df1[i][W-1:0];
          my[i] = df1[i][W-1:0];
        end
      end
      OP_CROSS: begin
        mx[0] = a1[1]; my[0] = b1[2];
        mx[1] = a1[2]; my[1] = b1[1];
        mx[2] = a1[2]; my[2] = b1[0];
        mx[3] = a1[0]; my[3] = b1[2];
        mx[4] = a1[0]; my[4] = b1[1];
        mx[5] = a1[1]; my[5] = b1[0];
      end
      OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          dm_c[i] = mag(b1[i]);
          dn_c[i] = b1[i][W-1];
        end
      end
      OP_DIVSCALAR: begin
        for (int i = 0; i < 3; i++) begin
          dm_c[i] = mag(f1);
          dn_c[i] = f1[W-1];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = a1[i];
          my[i] = b1[i];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= op1;
      for (int k = 0; k < 6; k++) begin
        p2[k] <= $signed(mx[k]) * $signed(my[k]);
      end
      for (int i = 0; i < 3; i++) begin
        asv2[i] <= as1[i][W-1:0];
      end
      asov2 <= as1[0][W] | as1[1][W] | as1[2][W];
      dov2  <= df1[0][W] | df1[1][W] | df1[2][W];
      nm2   <= nm_c;
      nn2   <= nn_c;
      dm2   <= dm_c;
      dn2   <= dn_c;
    end
  end

  // stage 3: sums, floor shift and saturation
  logic signed [XW-1:0] s3;
  logic signed [XW-1:0] lane_sh [3];
  logic signed [XW-1:0] cr_sh [3];
  logic [W:0]           lane_st [3];
  logic [W:0]           cr_st [3];
  logic [W:0]           sum_st;
  logic [2:0][W-1:0]    vec_c;
  logic [W-1:0]         sc_c;
  logic                 ovf_c;
  logic                 v3;
  op_t                  op3;

  always_comb begin
    s3 = sxp(p2[0]) + sxp(p2[1]) + sxp(p2[2]);
    sum_st = sat(s3 >>> F);
    for (int i = 0; i < 3; i++) begin
      lane_sh[i] = sxp(p2[i]) >>> F;
      lane_st[i] = sat(lane_sh[i]);
      cr_sh[i]   = (sxp(p2[2*i]) - sxp(p2[2*i+1])) >>> F;
      cr_st[i]   = sat(cr_sh[i]);
    end
    vec_c = '0;
    sc_c  = '0;
    ovf_c = 1'b0;
    unique case (op2)
      OP_ADD, OP_SUB: begin
        vec_c = asv2;
        ovf_c = asov2;
      end
      OP_MUL, OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          vec_c[i] = lane_st[i][W-1:0];
        end
        ovf_c = lane_st[0][W] | lane_st[1][W] | lane_st[2][W];
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          vec_c[i] = cr_st[i][W-1:0];
        end
        ovf_c = cr_st[0][W] | cr_st[1][W] | cr_st[2][W];
      end
      OP_DOT, OP_LENSQ: begin
        sc_c  = sum_st[W-1:0];
        ovf_c = sum_st[W];
      end
      OP_DIST: begin
        ovf_c = dov2;
      end
      default: begin
        ovf_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3        <= op2;
      fast_vec   <= vec_c;
      fast_sc    <= sc_c;
      fast_ovf   <= ovf_c;
      sumsq      <= s3[2*W-1:0];
      n_mag      <= nm2;
      n_neg      <= nn2;
      d_mag      <= dm2;
      d_neg      <= dn2;
    end
  end

  assign tag_out = '{valid: v3, op: op3};

endmodule

// File: hw/rtl/vau_sqrt.sv
// pipelined integer square root, one root bit per stage, with side data
module vau_sqrt import vau_pkg::*; #(
  parameter int W  = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [2*W-1:0] rad,
  input  logic [SW-1:0] side_in,
  output logic          out_v,
  output logic [W-1:0]  root,
  output logic [SW-1:0] side_out
);

  logic           v    [W+1];
  logic [W:0]     rem  [W+1];
  logic [W-1:0]   rt   [W+1];
  logic [2*W-1:0] sh   [W+1];
  logic [SW-1:0]  side [W+1];

  assign v[0]    = in_v;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign sh[0]   = rad;
  assign side[0] = side_in;

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W+1:0] remx, trial;
    logic         fits;

    // remainder stays at most twice the partial root
    assign remx  = {rem[k][W-1:0], sh[k][2*W-1 -: 2]};
    assign trial = {rt[k], 2'b01};
    assign fits  = remx >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? (W+1)'(remx - trial) : remx[W:0];
        rt[k+1]   <= {rt[k][W-2:0], fits};
        sh[k+1]   <= {sh[k][2*W-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_v    = v[W];
  assign root     = rt[W];
  assign side_out = side[W];

endmodule

// File: hw/rtl/vau_div.sv
// pipelined restoring divider, one quotient bit per stage, with side data
module vau_div import vau_pkg::*; #(
  parameter int NB = 48,
  parameter int DB = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [NB-1:0] dividend,
  input  logic [DB-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_v,
  output logic [NB-1:0] quot,
  output logic [SW-1:0] side_out
);

  logic          v    [NB+1];
  logic [DB-1:0] rem  [NB+1];
  logic [NB-1:0] q    [NB+1];
  logic [NB-1:0] n    [NB+1];
  logic [DB-1:0] d    [NB+1];
  logic [SW-1:0] side [NB+1];

  assign v[0]    = in_v;
  assign rem[0]  = '0;
  assign q[0]    = '0;
  assign n[0]    = dividend;
  assign d[0]    = divisor;
  assign side[0] = side_in;

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [DB:0] remx, dx;
    logic        fits;

    assign remx = {rem[k], n[k][NB-1]};
    assign dx   = {1'b0, d[k]};
    assign fits = remx >= dx;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? DB'(remx - dx) : remx[DB-1:0];
        q[k+1]    <= {q[k][NB-2:0], fits};
        n[k+1]    <= {n[k][NB-2:0], 1'b0};
        d[k+1]    <= d[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_v    = v[NB];
  assign quot     = q[NB];
  assign side_out = side[NB];

endmodule

// File: hw/rtl/vec3_arithmetic_unit.sv
// vector alu top level: front pipeline, square root, three dividers, output register
//
// vec3_arithmetic_unit takes one item per transfer on the request channel (req_valid,
// req_stall, req_type, a_*, b_*, factor) and returns exactly one result per item on
// the result channel (res_valid, res_stall, r_*, overflowed, div_by_zero), in order.
// every item runs the same pipeline: three front stages (add/sub, multiply,
// combine), WORD_BITS square root stages, WORD_BITS+FRAC_BITS divider stages and
// the output register. a new item can enter in every cycle while the result
// channel is not stalled; throughput is then one item per cycle, set by the
// fully pipelined root and divider units.
// when res_valid is high and res_stall is high the whole pipeline holds, the
// result stays on the ports unchanged and req_stall is raised; no item is lost
// or repeated. reset (rst, synchronous) empties the pipeline; res_valid is low
// in the cycle after reset. there are no configuration registers and no state
// that survives an item.
module vec3_arithmetic_unit import vau_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [3:0]                  req_type,
  input  logic signed [WORD_BITS-1:0] a_x,
  input  logic signed [WORD_BITS-1:0] a_y,
  input  logic signed [WORD_BITS-1:0] a_z,
  input  logic signed [WORD_BITS-1:0] b_x,
  input  logic signed [WORD_BITS-1:0] b_y,
  input  logic signed [WORD_BITS-1:0] b_z,
  input  logic signed [WORD_BITS-1:0] factor,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic signed [WORD_BITS-1:0] r_x,
  output logic signed [WORD_BITS-1:0] r_y,
  output logic signed [WORD_BITS-1:0] r_z,
  output logic signed [WORD_BITS-1:0] r_scalar,
  output logic                        overflowed,
  output logic                        div_by_zero
);

  `include "assert_macros.svh"

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NB  = W + F;
  localparam int SQW = 10*W + 11;
  localparam int D0W = 5*W + 8;
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [NB-1:0] QMAX = {{(F+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NB-1:0] QHALF = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic en;
  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;

  // front pipeline
  tag_t              tag_in, tag_f;
  logic [2:0][W-1:0] fa, fb;
  logic [2:0][W-1:0] f_vec, f_nmag, f_dmag;
  logic [W-1:0]      f_sc;
  logic              f_ovf;
  logic [2*W-1:0]    f_sumsq;
  logic [2:0]        f_nneg, f_dneg;

  assign tag_in = '{valid: req_valid, op: op_t'(req_type)};
  assign fa = {a_z, a_y, a_x};
  assign fb = {b_z, b_y, b_x};

  vau_front #(.W(W), .F(F)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .tag_in   (tag_in),
    .a        (fa),
    .b        (fb),
    .f        (factor),
    .tag_out  (tag_f),
    .fast_vec (f_vec),
    .fast_sc  (f_sc),
    .fast_ovf (f_ovf),
    .sumsq    (f_sumsq),
    .n_mag    (f_nmag),
    .n_neg    (f_nneg),
    .d_mag    (f_dmag),
    .d_neg    (f_dneg)
  );

  // square root of the sum of squares
  logic              sq_v;
  logic [W-1:0]      sq_root;
  logic [SQW-1:0]    sq_side;
  logic [3:0]        sq_op;
  logic [2:0][W-1:0] sq_vec, sq_nmag, sq_dmag;
  logic [W-1:0]      sq_sc;
  logic              sq_ovf;
  logic [2:0]        sq_nneg, sq_dneg;

  vau_sqrt #(.W(W), .SW(SQW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (tag_f.valid),
    .rad      (f_sumsq),
    .side_in  ({tag_f.op, f_vec, f_sc, f_ovf, f_nmag, f_nneg, f_dmag, f_dneg}),
    .out_v    (sq_v),
    .root     (sq_root),
    .side_out (sq_side)
  );

  assign {sq_op, sq_vec, sq_sc, sq_ovf, sq_nmag, sq_nneg, sq_dmag, sq_dneg} = sq_side;

  // divisor choice per lane: the root for normalize
  logic [2:0][W-1:0] dv_div;
  logic [2:0]        dv_qneg, dv_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op_t'(sq_op) == OP_NORM) begin
        dv_div[i]  = sq_root;
        dv_qneg[i] = sq_nneg[i];
      end else begin
        dv_div[i]  = sq_dmag[i];
        dv_qneg[i] = sq_nneg[i] ^ sq_dneg[i];
      end
      dv_zero[i] = dv_div[i] == '0;
    end
  end

  // dividers
  logic [2:0]        dq_v;
  logic [NB-1:0]     dq [3];
  logic [D0W-1:0]    d0_side;
  logic [2:0][2:0]   ln_side;
  logic [3:0]        fin_op_raw;
  logic [2:0][W-1:0] fin_vec_fast;
  logic [W-1:0]      fin_sc_fast;
  logic              fin_ovf_fast;
  logic [W-1:0]      fin_root;

  vau_div #(.NB(NB), .DB(W), .SW(D0W)) u_div0 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (sq_v),
    .dividend ({sq_nmag[0], {F{1'b0}}}),
    .divisor  (dv_div[0]),
    .side_in  ({sq_op, sq_vec, sq_sc, sq_ovf, sq_root,
                dv_qneg[0], sq_nneg[0], dv_zero[0]}),
    .out_v    (dq_v[0]),
    .quot     (dq[0]),
    .side_out (d0_side)
  );

  assign {fin_op_raw, fin_vec_fast, fin_sc_fast, fin_ovf_fast, fin_root, ln_side[0]} = d0_side;

  for (genvar l = 1; l < 3; l++) begin : g_lane
    vau_div #(.NB(NB), .DB(W), .SW(3)) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_v     (sq_v),
      .dividend ({sq_nmag[l], {F{1'b0}}}),
      .divisor  (dv_div[l]),
      .side_in  ({dv_qneg[l], sq_nneg[l], dv_zero[l]}),
      .out_v    (dq_v[l]),
      .quot     (dq[l]),
      .side_out (ln_side[l])
    );
  end

  // final select and saturation
  op_t               fin_op;
  logic              fin_v;
  logic [2:0][W-1:0] fin_vec;
  logic [W-1:0]      fin_sc;
  logic              fin_ovf, fin_dz;
  op_t               res_op;

  assign fin_op = op_t'(fin_op_raw);
  assign fin_v  = &dq_v;

  always_comb begin
    fin_vec = fin_vec_fast;
    fin_sc  = fin_sc_fast;
    fin_ovf = fin_ovf_fast;
    fin_dz  = 1'b0;
    unique case (fin_op)
      OP_DIV, OP_DIVSCALAR, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          // side bits per lane: quotient sign, dividend sign, zero divisor
          if (ln_side[i][0]) begin
            if (fin_op == OP_NORM) begin
              fin_vec[i] = '0;
            end else begin
              fin_vec[i] = ln_side[i][1] ? WMIN : WMAX;
              fin_dz     = 1'b1;
            end
          end else if (dq[i] == '0) begin
            fin_vec[i] = '0;
          end else if (!ln_side[i][2]) begin
            if (dq[i] > QMAX) begin
              fin_vec[i] = WMAX;
              fin_ovf    = 1'b1;
            end else begin
              fin_vec[i] = dq[i][W-1:0];
            end
          end else begin
            if (dq[i] > QHALF) begin
              fin_vec[i] = WMIN;
              fin_ovf    = 1'b1;
            end else begin
              fin_vec[i] = (~dq[i][W-1:0]) + W'(1);
            end
          end
        end
      end
      OP_LEN, OP_DIST: begin
        if (fin_root > WMAX) begin
          fin_sc  = WMAX;
          fin_ovf = 1'b1;
        end else begin
          fin_sc = fin_root;
        end
      end
      default: begin
        fin_sc = fin_sc_fast;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_x         <= fin_vec[0];
      r_y         <= fin_vec[1];
      r_z         <= fin_vec[2];
      r_scalar    <= fin_sc;
      overflowed  <= fin_ovf;
      div_by_zero <= fin_dz;
      res_op      <= fin_op;
    end
  end

  logic res_div_op, res_scalar_op;

  assign res_div_op    = res_op == OP_DIV || res_op == OP_DIVSCALAR;
  assign res_scalar_op = res_op == OP_LEN || res_op == OP_LENSQ ||
                         res_op == OP_DIST || res_op == OP_DOT;

  `VAU_ASSERT_NEXT(a_reset_empties, rst, !res_valid)
  `VAU_ASSERT_IMP(a_dz_only_div, res_valid && div_by_zero, res_div_op)
  `VAU_ASSERT_IMP(a_scalar_ops_zero_vec, res_valid && res_scalar_op, r_x == '0 && r_y == '0 && r_z == '0)

endmodule

// File: sim/tb_vec3_arithmetic_unit.sv
// self-checking testbench of the three-component fixed-point vector alu
module tb_vec3_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vau_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [31:0] word_t;

  typedef struct {
    logic [3:0] op;
    word_t      a[3];
    word_t      b[3];
    word_t      f;
  } vec_req_t;

  typedef struct {
    word_t r[3];
    word_t s;
    bit    ovf;
    bit    dz;
  } vec_res_t;

  localparam wide_t W_MAX = 128'sd2147483647;
  localparam wide_t W_MIN = -128'sd2147483648;
  localparam word_t WD_MAX = 32'sh7fffffff;
  localparam word_t WD_MIN = 32'sh80000000;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic [3:0] req_type;
  word_t      a_x, a_y, a_z, b_x, b_y, b_z, factor;
  logic       res_valid;
  logic       res_stall;
  word_t      r_x, r_y, r_z, r_scalar;
  logic       overflowed;
  logic       div_by_zero;

  vec_res_t expected_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       stall_pct = 0;
  int       gap_pct = 0;
  int       stall_left = 0;

  vec3_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .factor(factor),
    .res_valid(res_valid), .res_stall(res_stall),
    .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_scalar(r_scalar),
    .overflowed(overflowed), .div_by_zero(div_by_zero)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic word_t clamp(input wide_t v, inout bit ovf);
    if (v > W_MAX) begin
      ovf = 1'b1;
      return word_t'(W_MAX);
    end
    if (v < W_MIN) begin
      ovf = 1'b1;
      return word_t'(W_MIN);
    end
    return word_t'(v);
  endfunction

  // quotient truncates toward zero; zero divisor saturates by dividend sign
  function automatic word_t quotient(input wide_t n, input wide_t d, inout bit ovf,
                                     inout bit dz);
    if (d == 0) begin
      dz = 1'b1;
      return (n < 0) ? word_t'(W_MIN) : word_t'(W_MAX);
    end
    return clamp((n <<< 16) / d, ovf);
  endfunction

  function automatic wide_t floor_root(input wide_t s);
    wide_t r, t;
    r = 0;
    for (int k = 40; k >= 0; k--) begin
      t = r | (wide_t'(1) <<< k);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic vec_res_t predict_vec_op(input vec_req_t it);
    vec_res_t res;
    wide_t    a[3], b[3], t[3];
    wide_t    f, len;
    res.r = '{0, 0, 0};
    res.s = 0;
    res.ovf = 0;
    res.dz = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = it.a[i];
      b[i] = it.b[i];
    end
    f = it.f;
    case (op_t'(it.op))
      OP_ADD:
        for (int i = 0; i < 3; i++) res.r[i] = clamp(a[i] + b[i], res.ovf);
      OP_SUB:
        for (int i = 0; i < 3; i++) res.r[i] = clamp(a[i] - b[i], res.ovf);
      OP_MUL:
        for (int i = 0; i < 3; i++) res.r[i] = clamp((a[i] * b[i]) >>> 16, res.ovf);
      OP_DIV:
        for (int i = 0; i < 3; i++) res.r[i] = quotient(a[i], b[i], res.ovf, res.dz);
      OP_SCALE:
        for (int i = 0; i < 3; i++) res.r[i] = clamp((a[i] * f) >>> 16, res.ovf);
      OP_DIVSCALAR:
        for (int i = 0; i < 3; i++) res.r[i] = quotient(a[i], f, res.ovf, res.dz);
      OP_LEN:
        res.s = clamp(floor_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]), res.ovf);
      OP_LENSQ:
        res.s = clamp((a[0] * a[0] + a[1] * a[1] + a[2] * a[2]) >>> 16, res.ovf);
      OP_DIST: begin
        // difference saturates per component before the root
        for (int i = 0; i < 3; i++) t[i] = clamp(b[i] - a[i], res.ovf);
        res.s = clamp(floor_root(t[0] * t[0] + t[1] * t[1] + t[2] * t[2]), res.ovf);
      end
      OP_NORM: begin
        len = floor_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (len != 0)
          for (int i = 0; i < 3; i++) res.r[i] = quotient(a[i], len, res.ovf, res.dz);
      end
      OP_DOT:
        res.s = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16, res.ovf);
      OP_CROSS: begin
        res.r[0] = clamp((a[1] * b[2] - a[2] * b[1]) >>> 16, res.ovf);
        res.r[1] = clamp((a[2] * b[0] - a[0] * b[2]) >>> 16, res.ovf);
        res.r[2] = clamp((a[0] * b[1] - a[1] * b[0]) >>> 16, res.ovf);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 80);
    return $urandom_range(1, 3);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 8) * 32'h10000) - word_t'(32'h40000)
                + word_t'($urandom_range(0, 16'hffff));
      2: case ($urandom_range(0, 4))
           0: return word_t'(W_MAX);
           1: return word_t'(W_MIN);
           2: return 0;
           3: return -1;
           default: return 1;
         endcase
      3: return 0;
      default: return word_t'($urandom) >>> $urandom_range(0, 30);
    endcase
  endfunction

  // one transfer on the request side, then an optional random gap
  task automatic send_vec_op(input vec_req_t it);
    req_valid <= 1'b1;
    req_type  <= it.op;
    a_x <= it.a[0];
    a_y <= it.a[1];
    a_z <= it.a[2];
    b_x <= it.b[0];
    b_y <= it.b[1];
    b_z <= it.b[2];
    factor <= it.f;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_q.push_back(predict_vec_op(it));
    if ($urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [3:0] op, input word_t ax, input word_t ay,
                             input word_t az, input word_t bx, input word_t by,
                             input word_t bz, input word_t f);
    vec_req_t it;
    it.op = op;
    it.a = '{ax, ay, az};
    it.b = '{bx, by, bz};
    it.f = f;
    send_vec_op(it);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_every_op();
    for (int op = OP_ADD; op <= OP_CROSS; op++)
      send_fields(op[3:0], 32'sh18000, -32'sh28000, 32'sh7fff, 32'sh10000,
                  32'sh30000, -32'sh1, -32'sh20000);
  endtask

  task automatic test_saturation();
    send_fields(OP_ADD, WD_MAX, WD_MIN, 1, 1, -1, 5, 0);
    send_fields(OP_SUB, WD_MIN, WD_MAX, 0, 1, -1, 0, 0);
    send_fields(OP_MUL, WD_MIN, WD_MAX, -1, WD_MIN, WD_MAX, 1, 0);
    send_fields(OP_LEN, WD_MAX, WD_MAX, WD_MIN, 0, 0, 0, 0);
    send_fields(OP_LENSQ, WD_MIN, WD_MIN, WD_MIN, 0, 0, 0, 0);
    send_fields(OP_DIST, WD_MIN, WD_MAX, 0, WD_MAX, WD_MIN, 0, 0);
    send_fields(OP_DOT, WD_MAX, WD_MAX, WD_MAX, WD_MAX, WD_MAX, WD_MAX, 0);
    send_fields(OP_CROSS, WD_MIN, WD_MAX, WD_MIN, WD_MAX, WD_MIN, WD_MAX, 0);
    send_fields(OP_SCALE, WD_MIN, -1, 1, 0, 0, 0, WD_MIN);
  endtask

  task automatic test_div_by_zero();
    send_fields(OP_DIV, 32'sh10000, -32'sh10000, 0, 0, 0, 0, 0);
    send_fields(OP_DIVSCALAR, WD_MIN, WD_MAX, 0, 0, 0, 0, 0);
    send_fields(OP_DIV, WD_MAX, WD_MIN, 32'sh30000, 1, 1, -32'sh20000, 0);
    send_fields(OP_NORM, 0, 0, 0, 1, 1, 1, 0);
    send_fields(OP_NORM, 1, 0, -1, 0, 0, 0, 0);
  endtask

  task automatic test_unused_ops();
    for (int op = 12; op <= 15; op++)
      send_fields(op[3:0], WD_MAX, WD_MIN, -1, WD_MIN, WD_MAX, 1, 0);
  endtask

  task automatic test_random_ops(input int count);
    vec_req_t it;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        stall_pct = (n % 450 == 0) ? 0 : $urandom_range(5, 50);
        gap_pct   = (n % 300 == 0) ? 0 : $urandom_range(5, 50);
      end
      if (n == count / 2) wait_drained();
      it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                            : 4'($urandom_range(0, 11));
      for (int i = 0; i < 3; i++) begin
        it.a[i] = rand_word();
        it.b[i] = rand_word();
      end
      it.f = rand_word();
      send_vec_op(it);
    end
    req_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      res_stall <= 1'b0;
      if ($urandom_range(0, 99) < stall_pct) stall_left <= pick_gap();
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    vec_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        want = expected_q.pop_front();
        if (r_x !== want.r[0] || r_y !== want.r[1] || r_z !== want.r[2] ||
            r_scalar !== want.s || overflowed !== want.ovf || div_by_zero !== want.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h s=%h o=%b z=%b got %h %h %h s=%h o=%b z=%b",
                     want.r[0], want.r[1], want.r[2], want.s, want.ovf, want.dz,
                     r_x, r_y, r_z, r_scalar, overflowed, div_by_zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req_type <= '0;
    {a_x, a_y, a_z, b_x, b_y, b_z, factor} <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_every_op();
    test_saturation();
    test_div_by_zero();
    test_unused_ops();
    test_random_ops(1450);
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
